@@ rtl/indexed_linked_list_with_cursors_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-check shorthands for the linked list core RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LINKED_LIST_WITH_CURSORS_CORE_MACROS_SVH
`define INDEXED_LINKED_LIST_WITH_CURSORS_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define ILC_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, disabled in reset
`define ILC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

@@ rtl/ilc_pkg.sv @@
// ----------------------------------------------------------------------------
// ilc_pkg
// Types, sizes and helpers shared by the linked list core.
// ----------------------------------------------------------------------------
package ilc_pkg;

   localparam int TABLE_SIZE   = 256;
   localparam int CURSOR_COUNT = 4;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int CUR_W = $clog2(CURSOR_COUNT);
   localparam int ROW_W = 2 * IDX_W;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CUR_W-1:0] cur_sel_type;

   typedef enum logic [2:0] {
      OP_APPEND  = 3'd0,
      OP_REMOVE  = 3'd1,
      OP_QUERY   = 3'd2,
      OP_HEAD    = 3'd3,
      OP_ADVANCE = 3'd4,
      OP_CLEAR   = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_APP_LINK,
      S_APP_NEW,
      S_REM_GET,
      S_REM_NX_WR,
      S_REM_HEAD,
      S_REM_PV_WR,
      S_REM_CLR,
      S_QRY,
      S_ADV,
      S_FINISH
   } state_type;

   // one row of the link memory
   typedef struct packed {
      idx_type next_idx;
      idx_type prev_idx;
   } link_row_type;

   // request from the sequencer to the link store
   typedef struct packed {
      logic         rd_en;
      idx_type      rd_addr;
      logic         wr_en;
      idx_type      wr_addr;
      link_row_type wr_row;
      logic         clear_all;
   } link_req_type;

   // element index modulo TABLE_SIZE, as a constant lookup
   function automatic idx_type reduce_index(input logic [7:0] raw);
      idx_type lut [256];
      for (int k = 0; k < 256; k++) begin
         lut[k] = idx_type'(k % TABLE_SIZE);
      end
      return lut[raw];
   endfunction

   function automatic cur_sel_type sel_index(input logic [1:0] raw);
      logic [31:0] wide;
      wide = 32'(raw);
      return wide[CUR_W-1:0];
   endfunction

   function automatic logic sel_valid(input logic [1:0] raw);
      return 32'(raw) < 32'(CURSOR_COUNT);
   endfunction

   function automatic logic [7:0] to_byte(input idx_type v);
      logic [31:0] wide;
      wide = 32'(v);
      return wide[7:0];
   endfunction

endpackage

@@ rtl/ilc_ram.sv @@
// ----------------------------------------------------------------------------
// ilc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ilc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ilc_link_store.sv @@
// ----------------------------------------------------------------------------
// ilc_link_store
// Next/prev link memory with per-row valid bits; invalid rows read as zero.
// ----------------------------------------------------------------------------
`include "indexed_linked_list_with_cursors_core_macros.svh"

module ilc_link_store (
   input  logic                  clock,
   input  logic                  reset,
   input  ilc_pkg::link_req_type link_req,
   output ilc_pkg::link_row_type rd_row
);

   logic [ilc_pkg::TABLE_SIZE-1:0] valid_ff;
   logic [ilc_pkg::TABLE_SIZE-1:0] valid_in;
   logic                           rd_valid_ff;
   logic                           rd_valid_in;
   logic [ilc_pkg::ROW_W-1:0]      ram_rd_data;

   always_comb begin
      valid_in = valid_ff;
      if (link_req.clear_all) begin
         valid_in = '0;
      end else if (link_req.wr_en) begin
         valid_in[link_req.wr_addr] = 1'b1;
      end
      rd_valid_in = link_req.rd_en ? valid_ff[link_req.rd_addr] : rd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   ilc_ram #(
      .WIDTH (ilc_pkg::ROW_W),
      .DEPTH (ilc_pkg::TABLE_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (link_req.wr_en),
      .wr_addr (link_req.wr_addr),
      .wr_data (link_req.wr_row),
      .rd_en   (link_req.rd_en),
      .rd_addr (link_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_row = rd_valid_ff ? ilc_pkg::link_row_type'(ram_rd_data) : '0;

   // a row is read only when no write is in flight
   `ILC_ASSERT_SAME(a_no_rd_wr_overlap, clock, reset, link_req.rd_en, !link_req.wr_en)
   // clear drops every row and is never combined with a write
   `ILC_ASSERT_NEXT(a_clear_empties, clock, reset, link_req.clear_all, valid_ff == '0)
   // a written row is valid afterwards
   `ILC_ASSERT_NEXT(a_write_marks, clock, reset, link_req.wr_en, valid_ff[$past(link_req.wr_addr)])

endmodule

@@ rtl/indexed_linked_list_with_cursors_core.sv @@
// ----------------------------------------------------------------------------
// indexed_linked_list_with_cursors_core
// Doubly linked list of element indexes with head, tail and traversal cursors.
// ----------------------------------------------------------------------------
// One request at a time: append, remove, membership query, cursor to head,
// cursor advance or clear, each answered by exactly one response carrying the
// membership flag, the selected cursor, head and tail as they stand after the
// request. Links live in one single-port-per-direction memory (one read or one
// write per cycle, registered reads), so memory accesses set the pace: cursor
// to head, clear, unused opcodes and null-index append, remove or query need
// none; query and advance read one row; append reads and rewrites any old tail
// and writes the new row; remove reads the element and its neighbours, next
// unless at tail and previous unless at head, rewrites those and clears its
// own row. The response register frees the input side: a new request is taken
// as soon as the sequencer is idle, even while the previous response waits;
// the sequencer only stalls in its final state if that response is still
// unread. Clear is immediate: per-row valid bits drop at once, so there is
// no clearing pass after reset or clear. Unchecked misuse (appending a member,
// removing a non-member, index 0 links) updates the links exactly as given.
// ----------------------------------------------------------------------------
`include "indexed_linked_list_with_cursors_core_macros.svh"

module indexed_linked_list_with_cursors_core (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_op,
   input  logic [7:0] req_elem_index,
   input  logic [1:0] req_cursor_sel,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_member,
   output logic [7:0] rsp_cursor_elem,
   output logic [7:0] rsp_head_elem,
   output logic [7:0] rsp_tail_elem
);

   // sequencer state
   ilc_pkg::state_type    state_ff, state_in;
   // captured request
   ilc_pkg::op_type       op_ff, op_in;
   ilc_pkg::idx_type      elem_ff, elem_in;
   logic [1:0]            sel_ff, sel_in;
   // list state
   ilc_pkg::idx_type      head_ff, head_in;
   ilc_pkg::idx_type      tail_ff, tail_in;
   ilc_pkg::idx_type      cursor_ff [ilc_pkg::CURSOR_COUNT];
   ilc_pkg::idx_type      cursor_in [ilc_pkg::CURSOR_COUNT];
   // neighbors of the element being removed
   ilc_pkg::idx_type      nx_ff, nx_in;
   ilc_pkg::idx_type      pv_ff, pv_in;
   logic                  member_ff, member_in;
   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_member_ff, rsp_member_in;
   logic [7:0]            rsp_cursor_ff, rsp_cursor_in;
   logic [7:0]            rsp_head_ff, rsp_head_in;
   logic [7:0]            rsp_tail_ff, rsp_tail_in;

   ilc_pkg::link_req_type link_req;
   ilc_pkg::link_row_type rd_row;

   logic                  sel_ok;
   ilc_pkg::cur_sel_type  sel_idx;
   logic                  elem_nz;
   logic                  rsp_free;

   // terms used by the checks
   logic                  req_fire;
   logic                  fin_post;
   logic                  rd_data_used;

   assign sel_ok   = ilc_pkg::sel_valid(sel_ff);
   assign sel_idx  = ilc_pkg::sel_index(sel_ff);
   assign elem_nz  = (elem_ff != '0);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   ilc_link_store u_link_store (
      .clock    (clock),
      .reset    (reset),
      .link_req (link_req),
      .rd_row   (rd_row)
   );

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ilc_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = ilc_pkg::S_DECODE;
            end
         end
         ilc_pkg::S_DECODE: begin
            state_in = ilc_pkg::S_FINISH;
            case (op_ff)
               ilc_pkg::OP_APPEND: begin
                  if (elem_nz) begin
                     state_in = (tail_ff != '0) ? ilc_pkg::S_APP_LINK : ilc_pkg::S_APP_NEW;
                  end
               end
               ilc_pkg::OP_REMOVE: begin
                  if (elem_nz) begin
                     state_in = ilc_pkg::S_REM_GET;
                  end
               end
               ilc_pkg::OP_QUERY: begin
                  if (elem_nz) begin
                     state_in = ilc_pkg::S_QRY;
                  end
               end
               ilc_pkg::OP_ADVANCE: begin
                  if (sel_ok) begin
                     state_in = ilc_pkg::S_ADV;
                  end
               end
               default: begin
                  state_in = ilc_pkg::S_FINISH;
               end
            endcase
         end
         ilc_pkg::S_APP_LINK:  state_in = ilc_pkg::S_APP_NEW;
         ilc_pkg::S_APP_NEW:   state_in = ilc_pkg::S_FINISH;
         ilc_pkg::S_REM_GET: begin
            state_in = (elem_ff == tail_ff) ? ilc_pkg::S_REM_HEAD : ilc_pkg::S_REM_NX_WR;
         end
         ilc_pkg::S_REM_NX_WR: state_in = ilc_pkg::S_REM_HEAD;
         ilc_pkg::S_REM_HEAD: begin
            state_in = (elem_ff == head_ff) ? ilc_pkg::S_REM_CLR : ilc_pkg::S_REM_PV_WR;
         end
         ilc_pkg::S_REM_PV_WR: state_in = ilc_pkg::S_REM_CLR;
         ilc_pkg::S_REM_CLR:   state_in = ilc_pkg::S_FINISH;
         ilc_pkg::S_QRY:       state_in = ilc_pkg::S_FINISH;
         ilc_pkg::S_ADV:       state_in = ilc_pkg::S_FINISH;
         ilc_pkg::S_FINISH: begin
            if (rsp_free) begin
               state_in = ilc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ilc_pkg::S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // datapath and memory requests
   // ---------------------------------------------------------------------
   always_comb begin
      op_in         = op_ff;
      elem_in       = elem_ff;
      sel_in        = sel_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cursor_in     = cursor_ff;
      nx_in         = nx_ff;
      pv_in         = pv_ff;
      member_in     = member_ff;
      rsp_member_in = rsp_member_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_tail_in   = rsp_tail_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      link_req      = '0;

      case (state_ff)
         ilc_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in     = ilc_pkg::op_type'(req_op);
               elem_in   = ilc_pkg::reduce_index(req_elem_index);
               sel_in    = req_cursor_sel;
               member_in = 1'b0;
            end
         end
         ilc_pkg::S_DECODE: begin
            case (op_ff)
               ilc_pkg::OP_APPEND: begin
                  if (elem_nz) begin
                     // idle cursors jump onto the new element
                     for (int c = 0; c < ilc_pkg::CURSOR_COUNT; c++) begin
                        if (cursor_ff[c] == '0) begin
                           cursor_in[c] = elem_ff;
                        end
                     end
                     link_req.rd_en   = (tail_ff != '0);
                     link_req.rd_addr = tail_ff;
                  end
               end
               ilc_pkg::OP_REMOVE, ilc_pkg::OP_QUERY: begin
                  link_req.rd_en   = elem_nz;
                  link_req.rd_addr = elem_ff;
               end
               ilc_pkg::OP_HEAD: begin
                  if (sel_ok) begin
                     cursor_in[sel_idx] = head_ff;
                  end
               end
               ilc_pkg::OP_ADVANCE: begin
                  if (sel_ok) begin
                     link_req.rd_en   = 1'b1;
                     link_req.rd_addr = cursor_ff[sel_idx];
                  end
               end
               ilc_pkg::OP_CLEAR: begin
                  link_req.clear_all = 1'b1;
                  head_in            = '0;
                  tail_in            = '0;
                  for (int c = 0; c < ilc_pkg::CURSOR_COUNT; c++) begin
                     cursor_in[c] = '0;
                  end
               end
               default: begin
                  link_req = '0;
               end
            endcase
         end
         ilc_pkg::S_APP_LINK: begin
            // old tail now points forward to the new element
            link_req.wr_en           = 1'b1;
            link_req.wr_addr         = tail_ff;
            link_req.wr_row.next_idx = elem_ff;
            link_req.wr_row.prev_idx = rd_row.prev_idx;
         end
         ilc_pkg::S_APP_NEW: begin
            link_req.wr_en           = 1'b1;
            link_req.wr_addr         = elem_ff;
            link_req.wr_row.next_idx = '0;
            link_req.wr_row.prev_idx = tail_ff;
            tail_in                  = elem_ff;
            if (tail_ff == '0) begin
               head_in = elem_ff;
            end
         end
         ilc_pkg::S_REM_GET: begin
            nx_in = rd_row.next_idx;
            pv_in = rd_row.prev_idx;
            for (int c = 0; c < ilc_pkg::CURSOR_COUNT; c++) begin
               if (cursor_ff[c] == elem_ff) begin
                  cursor_in[c] = rd_row.next_idx;
               end
            end
            if (elem_ff == tail_ff) begin
               tail_in = rd_row.prev_idx;
            end else begin
               link_req.rd_en   = 1'b1;
               link_req.rd_addr = rd_row.next_idx;
            end
         end
         ilc_pkg::S_REM_NX_WR: begin
            link_req.wr_en           = 1'b1;
            link_req.wr_addr         = nx_ff;
            link_req.wr_row.next_idx = rd_row.next_idx;
            link_req.wr_row.prev_idx = pv_ff;
         end
         ilc_pkg::S_REM_HEAD: begin
            // read of pv is issued after the nx write, so it sees it
            if (elem_ff == head_ff) begin
               head_in = nx_ff;
            end else begin
               link_req.rd_en   = 1'b1;
               link_req.rd_addr = pv_ff;
            end
         end
         ilc_pkg::S_REM_PV_WR: begin
            link_req.wr_en           = 1'b1;
            link_req.wr_addr         = pv_ff;
            link_req.wr_row.next_idx = nx_ff;
            link_req.wr_row.prev_idx = rd_row.prev_idx;
         end
         ilc_pkg::S_REM_CLR: begin
            link_req.wr_en   = 1'b1;
            link_req.wr_addr = elem_ff;
            link_req.wr_row  = '0;
         end
         ilc_pkg::S_QRY: begin
            member_in = (elem_ff == head_ff) || (rd_row != '0);
         end
         ilc_pkg::S_ADV: begin
            cursor_in[sel_idx] = rd_row.next_idx;
         end
         ilc_pkg::S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_member_in = member_ff;
               rsp_cursor_in = sel_ok ? ilc_pkg::to_byte(cursor_ff[sel_idx]) : 8'd0;
               rsp_head_in   = ilc_pkg::to_byte(head_ff);
               rsp_tail_in   = ilc_pkg::to_byte(tail_ff);
            end
         end
         default: begin
            link_req = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ilc_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         for (int c = 0; c < ilc_pkg::CURSOR_COUNT; c++) begin
            cursor_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cursor_ff    <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      elem_ff       <= elem_in;
      sel_ff        <= sel_in;
      nx_ff         <= nx_in;
      pv_ff         <= pv_in;
      member_ff     <= member_in;
      rsp_member_ff <= rsp_member_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_tail_ff   <= rsp_tail_in;
   end

   assign req_ready       = (state_ff == ilc_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_member   = rsp_member_ff;
   assign rsp_cursor_elem = rsp_cursor_ff;
   assign rsp_head_elem   = rsp_head_ff;
   assign rsp_tail_elem   = rsp_tail_ff;

   assign req_fire     = req_valid && req_ready;
   assign fin_post     = (state_ff == ilc_pkg::S_FINISH) && rsp_free;
   assign rd_data_used = (state_ff == ilc_pkg::S_QRY) || (state_ff == ilc_pkg::S_ADV) ||
                         (state_ff == ilc_pkg::S_REM_GET) ||
                         (state_ff == ilc_pkg::S_APP_LINK) ||
                         (state_ff == ilc_pkg::S_REM_NX_WR) ||
                         (state_ff == ilc_pkg::S_REM_PV_WR);

   // an accepted request is decoded next
   `ILC_ASSERT_NEXT(a_accept_decode, clock, reset, req_fire, state_ff == ilc_pkg::S_DECODE)
   // states that consume read data follow a read issue
   `ILC_ASSERT_SAME(a_read_before_use, clock, reset, rd_data_used, $past(link_req.rd_en))
   // a finished request is posted once the response slot is free
   `ILC_ASSERT_NEXT(a_finish_posts, clock, reset, fin_post, rsp_valid && req_ready)

endmodule

@@ verif/tb_indexed_linked_list_with_cursors_core.sv @@
// ----------------------------------------------------------------------------
// tb_indexed_linked_list_with_cursors_core
// Self-checking bench for the indexed linked list core with cursors.
// ----------------------------------------------------------------------------
// A mirror of the link tables, head, tail and cursors predicts the response
// of every accepted request; responses are checked in order, field by field.
// A short directed run covers null and extreme indexes, every opcode, head,
// tail and middle removal, misuse and clear. A random run follows: mostly
// well-formed append, remove, query and cursor traffic, with some misuse,
// unused opcodes and occasional clears. Both sides idle at random, with one
// stretch that has no idling at all.
// ----------------------------------------------------------------------------
module tb_indexed_linked_list_with_cursors_core;
   timeunit 1ns;
   timeprecision 1ps;

   // opcodes without an enum member; the block must leave state alone
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   localparam int RANDOM_REQUESTS = 800;
   localparam int STALL_LIMIT     = 2000;  // cycles with no handshake at all
   localparam int TAIL_CYCLES     = 20;    // quiet time after the last response
   localparam int IDLE_PCT        = 19;

   // one response as seen on the rsp_ channel
   typedef struct packed {
      logic       is_member;
      logic [7:0] cursor_elem;
      logic [7:0] head_elem;
      logic [7:0] tail_elem;
   } list_view_type;

   // -------------------------------------------------------------------------
   // Mirror of the list plus the queue of responses still owed by the block
   // -------------------------------------------------------------------------
   class list_tracker;
      ilc_pkg::idx_type next_tbl   [ilc_pkg::TABLE_SIZE];
      ilc_pkg::idx_type prev_tbl   [ilc_pkg::TABLE_SIZE];
      ilc_pkg::idx_type cursor_tbl [ilc_pkg::CURSOR_COUNT];
      ilc_pkg::idx_type head_idx;
      ilc_pkg::idx_type tail_idx;
      list_view_type    owed_views [$];
      int               error_count;

      function new();
         error_count = 0;
         wipe();
      endfunction

      function void wipe();
         foreach (next_tbl[i]) begin
            next_tbl[i] = '0;
            prev_tbl[i] = '0;
         end
         foreach (cursor_tbl[c]) cursor_tbl[c] = '0;
         head_idx = '0;
         tail_idx = '0;
      endfunction

      function bit is_listed(ilc_pkg::idx_type e);
         return e != 0 && (e == head_idx || prev_tbl[e] != 0 || next_tbl[e] != 0);
      endfunction

      // walk a short random distance from head; tail now and then
      function ilc_pkg::idx_type pick_listed();
         ilc_pkg::idx_type e;
         int               steps;
         if (head_idx == 0) return ilc_pkg::idx_type'($urandom_range(1, 255));
         if ($urandom_range(0, 3) == 0) return tail_idx;
         e     = head_idx;
         steps = $urandom_range(0, 31);
         for (int i = 0; i < steps && next_tbl[e] != 0; i++) e = next_tbl[e];
         return e;
      endfunction

      // random index that is not in the list, if one turns up quickly
      function ilc_pkg::idx_type pick_unlisted();
         ilc_pkg::idx_type e;
         for (int i = 0; i < 32; i++) begin
            e = ilc_pkg::idx_type'($urandom_range(1, 255));
            if (!is_listed(e)) return e;
         end
         return e;
      endfunction

      function int pending();
         return owed_views.size();
      endfunction

      // apply one accepted request to the mirror and queue its response
      function void note_request(logic [2:0] op, logic [7:0] elem, logic [1:0] sel);
         ilc_pkg::idx_type e;
         ilc_pkg::idx_type nx;
         ilc_pkg::idx_type pv;
         bit               sel_ok;
         list_view_type    view;
         e      = ilc_pkg::idx_type'(elem % ilc_pkg::TABLE_SIZE);
         sel_ok = int'(sel) < ilc_pkg::CURSOR_COUNT;
         view   = '0;
         case (op)
            ilc_pkg::OP_APPEND: begin
               if (e != 0) begin
                  foreach (cursor_tbl[c]) if (cursor_tbl[c] == 0) cursor_tbl[c] = e;
                  if (tail_idx != 0) begin
                     next_tbl[tail_idx] = e;
                     prev_tbl[e]        = tail_idx;
                  end else begin
                     prev_tbl[e] = '0;
                     head_idx    = e;
                  end
                  next_tbl[e] = '0;
                  tail_idx    = e;
               end
            end
            ilc_pkg::OP_REMOVE: begin
               if (e != 0) begin
                  nx = next_tbl[e];
                  pv = prev_tbl[e];
                  foreach (cursor_tbl[c]) if (cursor_tbl[c] == e) cursor_tbl[c] = nx;
                  if (e == tail_idx) tail_idx = pv;
                  else prev_tbl[nx] = pv;
                  if (e == head_idx) head_idx = nx;
                  else next_tbl[pv] = nx;
                  next_tbl[e] = '0;
                  prev_tbl[e] = '0;
               end
            end
            ilc_pkg::OP_QUERY:   view.is_member = is_listed(e);
            ilc_pkg::OP_HEAD:    if (sel_ok) cursor_tbl[sel] = head_idx;
            ilc_pkg::OP_ADVANCE: if (sel_ok) cursor_tbl[sel] = next_tbl[cursor_tbl[sel]];
            ilc_pkg::OP_CLEAR:   wipe();
            default: ;
         endcase
         if (sel_ok) view.cursor_elem = 8'(cursor_tbl[sel]);
         view.head_elem = 8'(head_idx);
         view.tail_elem = 8'(tail_idx);
         owed_views.push_back(view);
      endfunction

      function void check_response(list_view_type got);
         list_view_type want;
         if (owed_views.size() == 0) begin
            $display("%0t: response with nothing owed: member %0d cursor %0d head %0d tail %0d",
                     $time, got.is_member, got.cursor_elem, got.head_elem, got.tail_elem);
            error_count++;
            return;
         end
         want = owed_views.pop_front();
         if (got.is_member !== want.is_member) begin
            $display("%0t: is_member expected %0d actual %0d",
                     $time, want.is_member, got.is_member);
            error_count++;
         end
         if (got.cursor_elem !== want.cursor_elem) begin
            $display("%0t: cursor_elem expected %0d actual %0d",
                     $time, want.cursor_elem, got.cursor_elem);
            error_count++;
         end
         if (got.head_elem !== want.head_elem) begin
            $display("%0t: head_elem expected %0d actual %0d",
                     $time, want.head_elem, got.head_elem);
            error_count++;
         end
         if (got.tail_elem !== want.tail_elem) begin
            $display("%0t: tail_elem expected %0d actual %0d",
                     $time, want.tail_elem, got.tail_elem);
            error_count++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [2:0] req_op;
   logic [7:0] req_elem_index;
   logic [1:0] req_cursor_sel;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_is_member;
   logic [7:0] rsp_cursor_elem;
   logic [7:0] rsp_head_elem;
   logic [7:0] rsp_tail_elem;

   list_tracker tracker = new();
   int          idle_pct = IDLE_PCT;  // shared by both sides; 0 = no idling
   int          quiet_cycles = 0;

   indexed_linked_list_with_cursors_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_elem_index  (req_elem_index),
      .req_cursor_sel  (req_cursor_sel),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_member   (rsp_is_member),
      .rsp_cursor_elem (rsp_cursor_elem),
      .rsp_head_elem   (rsp_head_elem),
      .rsp_tail_elem   (rsp_tail_elem)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // Called at a rising edge. A gap drops valid first; with no gap valid stays
   // high from the previous request and only the payload changes, so valid is
   // never lowered and raised within one step.
   task automatic send_request(logic [2:0] op, logic [7:0] elem, logic [1:0] sel);
      int gap;
      if ($urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_elem_index <= elem;
      req_cursor_sel <= sel;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(op, elem, sel);
   endtask

   // hold off until the block owes nothing
   task automatic wait_drained();
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Response side: check on handshake, then pick next cycle's ready
   // -------------------------------------------------------------------------
   initial begin
      list_view_type got;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.is_member   = rsp_is_member;
            got.cursor_elem = rsp_cursor_elem;
            got.head_elem   = rsp_head_elem;
            got.tail_elem   = rsp_tail_elem;
            tracker.check_response(got);
         end
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: too long with no handshake on either channel ends the run
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int         roll;
      int         kind;
      logic [2:0] op;
      logic [7:0] elem;
      logic [1:0] sel;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_op         <= ilc_pkg::OP_APPEND;
      req_elem_index <= '0;
      req_cursor_sel <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      send_request(ilc_pkg::OP_QUERY,   8'd0,   2'd0);  // empty list, null index
      send_request(ilc_pkg::OP_APPEND,  8'd0,   2'd1);  // null append is a no-op
      send_request(ilc_pkg::OP_REMOVE,  8'd0,   2'd2);  // null remove is a no-op
      send_request(ilc_pkg::OP_APPEND,  8'd255, 2'd3);  // first element, all cursors jump
      send_request(ilc_pkg::OP_APPEND,  8'd1,   2'd2);
      send_request(ilc_pkg::OP_APPEND,  8'd128, 2'd1);
      send_request(ilc_pkg::OP_APPEND,  8'h55,  2'd0);
      send_request(ilc_pkg::OP_APPEND,  8'hAA,  2'd3);
      send_request(ilc_pkg::OP_QUERY,   8'd255, 2'd0);
      send_request(ilc_pkg::OP_QUERY,   8'd2,   2'd1);
      send_request(ilc_pkg::OP_HEAD,    8'd0,   2'd0);
      send_request(ilc_pkg::OP_ADVANCE, 8'd0,   2'd0);
      send_request(ilc_pkg::OP_ADVANCE, 8'd0,   2'd1);
      send_request(ilc_pkg::OP_HEAD,    8'd0,   2'd3);
      send_request(ilc_pkg::OP_REMOVE,  8'd255, 2'd3);  // head, cursors on it move on
      send_request(ilc_pkg::OP_REMOVE,  8'hAA,  2'd2);  // tail
      send_request(ilc_pkg::OP_REMOVE,  8'd128, 2'd1);  // middle
      send_request(ilc_pkg::OP_REMOVE,  8'd77,  2'd0);  // not a member: links damaged
      send_request(ilc_pkg::OP_APPEND,  8'd1,   2'd2);  // already a member
      send_request(OP_SPARE_A,          8'hFF,  2'd1);
      send_request(OP_SPARE_B,          8'd0,   2'd2);
      send_request(ilc_pkg::OP_ADVANCE, 8'd0,   2'd2);
      send_request(ilc_pkg::OP_CLEAR,   8'd0,   2'd0);  // clear on a damaged list
      send_request(ilc_pkg::OP_QUERY,   8'h55,  2'd3);
      send_request(ilc_pkg::OP_ADVANCE, 8'd0,   2'd3);  // advance from null on empty list

      // sender holds off until every response is back
      req_valid <= 1'b0;
      wait_drained();

      // --- random part ---
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         // one long stretch without idling on either side
         idle_pct = (n >= 300 && n < 500) ? 0 : IDLE_PCT;
         if (n == 600) begin
            req_valid <= 1'b0;
            wait_drained();
         end
         roll = $urandom_range(0, 99);
         sel  = 2'($urandom_range(0, 3));
         elem = 8'($urandom_range(0, 255));
         if (roll < 2) begin
            op = ilc_pkg::OP_CLEAR;
         end else if (roll < 10) begin
            // misuse and unused opcodes with any index
            op = 3'($urandom_range(0, 7));
         end else begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
               op   = ilc_pkg::OP_APPEND;
               elem = 8'(tracker.pick_unlisted());
            end else if (kind < 55) begin
               op   = ilc_pkg::OP_REMOVE;
               elem = 8'(tracker.pick_listed());
            end else if (kind < 70) begin
               op = ilc_pkg::OP_QUERY;
               if ($urandom_range(0, 1)) elem = 8'(tracker.pick_listed());
            end else if (kind < 85) begin
               op = ilc_pkg::OP_HEAD;
            end else begin
               op = ilc_pkg::OP_ADVANCE;
            end
         end
         send_request(op, elem, sel);
      end
      req_valid <= 1'b0;

      // --- wrap up ---
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.error_count == 0 && tracker.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
